>>> hdl/rotation_to_euler_with_increments_macros.svh
// Assertion macros for the checker of the rotation-to-Euler block.
// Depends on nothing; included by the checker module.
`ifndef ROTATION_TO_EULER_WITH_INCREMENTS_MACROS_SVH
`define ROTATION_TO_EULER_WITH_INCREMENTS_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RTE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define RTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/rte_pkg.sv
// Package for the rotation-to-Euler block: widths, constants, CORDIC table, FSM type.
// No dependencies.
package rte_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;
    localparam int DW = 36;
    localparam int ZW = 34;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SY_LOAD, ST_SY_RUN, ST_SY_MAG,
        ST_P_LOAD, ST_P_RUN, ST_R_LOAD, ST_R_RUN,
        ST_Y_LOAD, ST_Y_RUN, ST_STEP, ST_OUT
    } rte_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rte_cordic_ctl_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] t;
        begin
            case (i)
                5'd0: t = 34'h020000000;
                5'd1: t = 34'h012E4051E;
                5'd2: t = 34'h009FB385B;
                5'd3: t = 34'h0051111D4;
                5'd4: t = 34'h0028B0D43;
                5'd5: t = 34'h00145D7E1;
                5'd6: t = 34'h000A2F61E;
                5'd7: t = 34'h000517C55;
                5'd8: t = 34'h00028BE53;
                5'd9: t = 34'h000145F2F;
                5'd10: t = 34'h0000A2F98;
                5'd11: t = 34'h0000517CC;
                5'd12: t = 34'h000028BE6;
                5'd13: t = 34'h0000145F3;
                5'd14: t = 34'h000000A2F9;
                5'd15: t = 34'h00000517C;
                5'd16: t = 34'h0000028BE;
                5'd17: t = 34'h00000145F;
                5'd18: t = 34'h000000A2F;
                5'd19: t = 34'h000000517;
                5'd20: t = 34'h00000028B;
                5'd21: t = 34'h000000145;
                5'd22: t = 34'h0000000A2;
                5'd23: t = 34'h000000051;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage

>>> hdl/rte_if.sv
// Valid/ready channel interfaces for the rotation-to-Euler block.
// Depends on rte_pkg only through the users.
interface rte_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    modport source (output valid, r00, r10, r11, r12, r20, r21, r22, input ready);
    modport sink (input valid, r00, r10, r11, r12, r20, r21, r22, output ready);
endinterface

interface rte_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [16:0] roll_step;
    logic signed [16:0] pitch_step;
    logic signed [16:0] yaw_step;
    logic singular;
    modport source (output valid, roll, pitch, yaw, roll_step, pitch_step, yaw_step,
                    singular, input ready);
    modport sink (input valid, roll, pitch, yaw, roll_step, pitch_step, yaw_step,
                  singular, output ready);
endinterface

interface rte_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hdl/rotation_to_euler_with_increments.sv
// Rotation matrix to XYZ Euler angles with frame-to-frame increments.
// Accepts one request at a time. The sy, pitch, roll and yaw vectoring passes
// run one after another on the one shared CORDIC unit. A pass is a load state
// and a run state that waits for the CORDIC done flag; when both operands are
// zero the CORDIC flags done without iterating. Ready also stays low through
// the sy scaling state and the wrap state. On the gimbal-lock branch the yaw
// pass is skipped. A finished result sits in the output register until taken.
// Any output stall adds to the busy time. The block then returns to idle,
// where it takes the next request.
// Depends on rte_pkg, rte_if and rte_cordic.
module rotation_to_euler_with_increments
    import rte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rte_in_if.sink     in_ch,
    rte_out_if.source  out_ch,
    rte_cfg_if.sink    cfg
);
    rte_state_t state_reg, state_next;
    logic [15:0] thr_reg;
    logic signed [15:0] r00_reg, r10_reg, r11_reg, r12_reg, r20_reg, r21_reg, r22_reg;
    logic [15:0] sy_reg;
    logic        sing_reg;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [15:0] last_roll_reg, last_pitch_reg, last_yaw_reg;
    logic        last_valid_reg;
    logic signed [16:0] droll_reg, dpitch_reg, dyaw_reg;
    logic        out_valid_reg;

    logic        cstart;
    logic signed [17:0] cx, cy;
    rte_cordic_ctl_t cctl;
    logic signed [ZW-1:0] cz;
    logic [DW-1:0] cxo;
    logic signed [15:0] ang_q13;
    logic [15:0] sy_val;
    logic [53:0] magp;
    logic [32:0] zabs;
    logic [63:0] qp;
    logic [16:0] qm;

    rte_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .x_in(cx), .y_in(cy),
        .ctl(cctl), .z_out(cz), .x_out(cxo)
    );

    // Binary angle to Q3.13 with half-away rounding and saturation.
    always_comb
    begin
        zabs = cz[ZW-1] ? 33'(-cz) : 33'(cz);
        qp = 64'(zabs) * 64'(PI_Q29) + (64'd1 << 46);
        qm = (qp[63:47] > 17'(PI_Q13)) ? 17'(PI_Q13) : qp[63:47];
        ang_q13 = cz[ZW-1] ? -16'(qm) : 16'(qm);
        magp = 54'(cxo[36-1:0]) * 54'(INV_GAIN_Q16) + (54'd1 << 23);
        sy_val = 16'(magp[53:24]);
    end

    function automatic logic signed [16:0] wrap_step(input logic signed [15:0] p,
                                                      input logic signed [15:0] c);
        logic signed [18:0] v1, v2, pa, ca, a1, a2, r;
        begin
            v1 = 19'(p) - 19'(c);
            pa = p[15] ? -19'(PI_Q13) - 19'(p) : 19'(PI_Q13) - 19'(p);
            ca = c[15] ? -19'(PI_Q13) - 19'(c) : 19'(PI_Q13) - 19'(c);
            v2 = pa - ca;
            a1 = v1[18] ? -v1 : v1;
            a2 = v2[18] ? -v2 : v2;
            if (p[15] == c[15] || a1 < a2)
                r = v1;
            else
                r = v2;
            if (r < -19'sd65536)
                r = -19'sd65536;
            else if (r > 19'sd65535)
                r = 19'sd65535;
            return r[16:0];
        end
    endfunction

    // Next-state sequencing.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_ch.valid && in_ch.ready) state_next = ST_SY_LOAD;
            ST_SY_LOAD: state_next = ST_SY_RUN;
            ST_SY_RUN:  if (cctl.done) state_next = ST_SY_MAG;
            ST_SY_MAG:  state_next = ST_P_LOAD;
            ST_P_LOAD:  state_next = ST_P_RUN;
            ST_P_RUN:   if (cctl.done) state_next = ST_R_LOAD;
            ST_R_LOAD:  state_next = ST_R_RUN;
            ST_R_RUN:   if (cctl.done) state_next = sing_reg ? ST_STEP : ST_Y_LOAD;
            ST_Y_LOAD:  state_next = ST_Y_RUN;
            ST_Y_RUN:   if (cctl.done) state_next = ST_STEP;
            ST_STEP:    state_next = ST_OUT;
            ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared CORDIC.
    always_comb
    begin
        cstart = 1'b0;
        cx = 18'(r00_reg);
        cy = 18'(r10_reg);
        case (state_reg)
            ST_SY_LOAD: cstart = 1'b1;
            ST_P_LOAD:
            begin
                cstart = 1'b1;
                cx = 18'($signed({1'b0, sy_reg}));
                cy = -18'(r20_reg);
            end
            ST_R_LOAD:
            begin
                cstart = 1'b1;
                cx = sing_reg ? 18'(r11_reg) : 18'(r22_reg);
                cy = sing_reg ? 18'(r12_reg) : 18'(r21_reg);
            end
            ST_Y_LOAD: cstart = 1'b1;
            default: cstart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= 16'd1;
            last_valid_reg <= 1'b0;
            last_roll_reg <= '0;
            last_pitch_reg <= '0;
            last_yaw_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                thr_reg <= cfg.data;
            if (state_reg == ST_STEP)
            begin
                // Advance the history and raise the result.
                last_roll_reg <= roll_reg;
                last_pitch_reg <= pitch_reg;
                last_yaw_reg <= yaw_reg;
                last_valid_reg <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_OUT && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            r00_reg <= in_ch.r00;
            r10_reg <= in_ch.r10;
            r11_reg <= in_ch.r11;
            r12_reg <= in_ch.r12;
            r20_reg <= in_ch.r20;
            r21_reg <= in_ch.r21;
            r22_reg <= in_ch.r22;
        end
        if (state_reg == ST_SY_MAG)
        begin
            sy_reg <= sy_val;
            sing_reg <= (sy_val < thr_reg);
            yaw_reg <= '0;
        end
        if (state_reg == ST_P_RUN && cctl.done)
            pitch_reg <= ang_q13;
        if (state_reg == ST_R_RUN && cctl.done)
            roll_reg <= ang_q13;
        if (state_reg == ST_Y_RUN && cctl.done)
            yaw_reg <= ang_q13;
        if (state_reg == ST_STEP)
        begin
            droll_reg <= last_valid_reg ? wrap_step(last_roll_reg, roll_reg) : '0;
            dpitch_reg <= last_valid_reg ? wrap_step(last_pitch_reg, pitch_reg) : '0;
            dyaw_reg <= last_valid_reg ? wrap_step(last_yaw_reg, yaw_reg) : '0;
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.roll = roll_reg;
    assign out_ch.pitch = pitch_reg;
    assign out_ch.yaw = yaw_reg;
    assign out_ch.roll_step = droll_reg;
    assign out_ch.pitch_step = dpitch_reg;
    assign out_ch.yaw_step = dyaw_reg;
    assign out_ch.singular = sing_reg;
endmodule

>>> hdl/rte_cordic.sv
// Shared iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on rte_pkg (table, widths, control struct).
module rte_cordic
    import rte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [17:0]    x_in,
    input  logic signed [17:0]    y_in,
    output rte_cordic_ctl_t       ctl,
    output logic signed [ZW-1:0]  z_out,
    output logic [DW-1:0]         x_out
);
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]    i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [DW-1:0] dx, dy, xs, ys;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        xs = DW'(x_in) <<< 8;
        ys = DW'(y_in) <<< 8;
        if (start)
        begin
            i_next = '0;
            if (x_in == 0 && y_in == 0)
            begin
                x_next = '0;
                y_next = '0;
                z_next = '0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (x_in < 0)
            begin
                x_next = -xs;
                y_next = -ys;
                z_next = (y_in >= 0) ? ZW'(64'sh80000000) : -ZW'(64'sh80000000);
                busy_next = 1'b1;
            end
            else
            begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + $signed(atan_entry(i_reg));
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - $signed(atan_entry(i_reg));
            end
            i_next = i_reg + 1'b1;
            if (32'(i_reg) == CORDIC_STEPS - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign z_out = z_reg;
    assign x_out = x_reg;
endmodule

>>> hdl/rte_checker.sv
// Port-level checker for the rotation-to-Euler block, bound to the top level.
// Depends on rte_if and the assertion macro header.
`include "rotation_to_euler_with_increments_macros.svh"
module rte_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic singular,
    input logic signed [15:0] yaw,
    input logic signed [15:0] roll
);
    `RTE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after accept")
    `RTE_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "new request taken while result pending")
    `RTE_ASSERT_IMPL(a_yaw_zero, clk, rst_n, out_valid && singular, yaw == 16'sd0, "yaw nonzero when singular")
    `RTE_ASSERT_IMPL(a_roll_range, clk, rst_n, out_valid, roll <= 16'sd25736 && roll >= -16'sd25736, "roll out of range")
endmodule

bind rotation_to_euler_with_increments rte_checker u_rte_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .singular(out_ch.singular),
    .yaw(out_ch.yaw), .roll(out_ch.roll)
);

>>> tb/rte_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (rte_if.sv); this file holds the
// scoreboard class used by the top level. No dependencies.
package rte_tb_pkg;
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [16:0] roll_step;
        logic signed [16:0] pitch_step;
        logic signed [16:0] yaw_step;
        logic               singular;
    } euler_t;

    localparam int NSTEPS = 16;
    localparam longint HALF = 64'sd2147483648;
    localparam longint PIQ = 25736;

    class euler_scoreboard;
        logic [15:0] threshold;
        longint      prev_roll, prev_pitch, prev_yaw;
        bit          have_prev;
        euler_t      pending[$];
        int          errors;

        function new();
            threshold = 16'd1;
            have_prev = 0;
            prev_roll = 0;
            prev_pitch = 0;
            prev_yaw = 0;
            errors = 0;
        endfunction

        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint vector_angle(longint y, longint x, output longint mag);
            longint z, dx, dy;
            longint tab[24];
            tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
                    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
            z = 0;
            if (x == 0 && y == 0)
            begin
                mag = 0;
                return 0;
            end
            if (x < 0)
            begin
                z = (y >= 0) ? HALF : -HALF;
                x = -x;
                y = -y;
            end
            x = x * 256;
            y = y * 256;
            for (int i = 0; i < NSTEPS; i++)
            begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y >= 0)
                begin
                    x += dx;
                    y -= dy;
                    z += tab[i];
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= tab[i];
                end
            end
            mag = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
            return z;
        endfunction

        static function longint angle_q13(longint y, longint x);
            longint m, q, unused;
            logic [127:0] p;
            m = vector_angle(y, x, unused);
            p = 128'(m < 0 ? -m : m) * 128'd1686629713 + (128'd1 << 46);
            q = longint'(p >> 47);
            if (m < 0)
                q = -q;
            return q < -PIQ ? -PIQ : (q > PIQ ? PIQ : q);
        endfunction

        static function longint wrapped_step(longint p, longint c);
            longint v1, v2, pa, ca, d;
            if ((p < 0) == (c < 0))
                d = p - c;
            else
            begin
                pa = p < 0 ? -PIQ - p : PIQ - p;
                ca = c < 0 ? -PIQ - c : PIQ - c;
                v1 = p - c;
                v2 = pa - ca;
                d = ((v1 < 0 ? -v1 : v1) < (v2 < 0 ? -v2 : v2)) ? v1 : v2;
            end
            return d < -65536 ? -65536 : (d > 65535 ? 65535 : d);
        endfunction

        // note an accepted request and queue its expected result
        function void note_request(logic signed [15:0] m[7]);
            longint sy, r, p, y;
            euler_t e;
            void'(vector_angle(m[1], m[0], sy));
            e.singular = sy < longint'(threshold);
            p = angle_q13(-longint'(m[4]), sy);
            if (!e.singular)
            begin
                r = angle_q13(m[5], m[6]);
                y = angle_q13(m[1], m[0]);
            end
            else
            begin
                r = angle_q13(m[3], m[2]);
                y = 0;
            end
            e.roll = 16'(r);
            e.pitch = 16'(p);
            e.yaw = 16'(y);
            e.roll_step = have_prev ? 17'(wrapped_step(prev_roll, r)) : 17'sd0;
            e.pitch_step = have_prev ? 17'(wrapped_step(prev_pitch, p)) : 17'sd0;
            e.yaw_step = have_prev ? 17'(wrapped_step(prev_yaw, y)) : 17'sd0;
            prev_roll = r;
            prev_pitch = p;
            prev_yaw = y;
            have_prev = 1;
            pending.push_back(e);
        endfunction

        function void check_result(euler_t got);
            euler_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e !== got)
            begin
                $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d",
                         $time, e.roll, e.pitch, e.yaw);
                $display("%0t:   expected steps %0d %0d %0d sing %0b",
                         $time, e.roll_step, e.pitch_step, e.yaw_step, e.singular);
                $display("%0t:   actual roll %0d pitch %0d yaw %0d",
                         $time, got.roll, got.pitch, got.yaw);
                $display("%0t:   actual steps %0d %0d %0d sing %0b",
                         $time, got.roll_step, got.pitch_step, got.yaw_step,
                         got.singular);
                errors++;
            end
        endfunction
    endclass
endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for rotation_to_euler_with_increments: directed and random
// rotation requests, predicted by the scoreboard in rte_tb_pkg. Depends on rte_pkg,
// rte_if and rte_tb_pkg.
module tb_top;
    import rte_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    longint cycle_count = 0;

    rte_in_if  in_ch();
    rte_out_if out_ch();
    rte_cfg_if cfg();

    rotation_to_euler_with_increments i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    euler_scoreboard board;

    // receiver shaping: random stalls, a quiet stretch, and one long hold-off
    bit calm_sink;
    bit hold_sink;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // watchdog: end the run if something hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sink side: drive ready, check every accepted result
    always @(posedge clk)
    begin
        euler_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.roll = out_ch.roll;
                got.pitch = out_ch.pitch;
                got.yaw = out_ch.yaw;
                got.roll_step = out_ch.roll_step;
                got.pitch_step = out_ch.pitch_step;
                got.yaw_step = out_ch.yaw_step;
                got.singular = out_ch.singular;
                board.check_result(got);
            end
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (calm_sink)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= 33);
        end
    end

    // write the threshold register; only called while the block is idle
    task automatic write_threshold(logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.threshold = value;
    endtask

    // offer one request, with an optional random gap first; valid stays high
    // after the accept until the next gap or a stop_input
    task automatic send_request(logic signed [15:0] m[7], bit gaps);
        if (gaps)
            while ($urandom_range(99) < 33)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        in_ch.valid <= 1'b1;
        in_ch.r00 <= m[0];
        in_ch.r10 <= m[1];
        in_ch.r11 <= m[2];
        in_ch.r12 <= m[3];
        in_ch.r20 <= m[4];
        in_ch.r21 <= m[5];
        in_ch.r22 <= m[6];
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_request(m);
    endtask

    // drop valid right after an accept, while the block is still busy
    task automatic stop_input();
        in_ch.valid <= 1'b0;
    endtask

    // wait until all results are back, then let the block settle
    task automatic drain();
        stop_input();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // random rotation-like matrix: mostly plausible magnitudes, sometimes noise
    task automatic random_request(bit gaps);
        logic signed [15:0] m[7];
        int mode;
        mode = $urandom_range(9);
        foreach (m[k])
        begin
            if (mode < 6)
                m[k] = $signed(16'($urandom_range(32767))) - 16'sd16384;
            else if (mode < 8)
                m[k] = 16'($urandom);
            else
                m[k] = $signed(16'($urandom_range(8))) - 16'sd4;
        end
        if (mode == 9)
        begin
            m[2] = 16'($urandom);
            m[3] = 16'($urandom);
        end
        send_request(m, gaps);
    endtask

    initial
    begin
        logic signed [15:0] m[7];
        logic signed [15:0] ext[5];
        logic [15:0] settings[4];
        ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh4000, 16'shC000};
        settings = '{16'd0, 16'hFFFF, 16'd8000, 16'd300};
        board = new();
        calm_sink = 0;
        hold_sink = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.r00 = '0;
        in_ch.r10 = '0;
        in_ch.r11 = '0;
        in_ch.r12 = '0;
        in_ch.r20 = '0;
        in_ch.r21 = '0;
        in_ch.r22 = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, all-zero atan2 operands, extremes, branch flips
        m = '{16'sh4000, 0, 16'sh4000, 0, 0, 0, 16'sh4000};
        send_request(m, 0);
        m = '{0, 0, 0, 0, 0, 0, 0};
        send_request(m, 0);
        for (int i = 0; i < 5; i++)
        begin
            foreach (m[k])
                m[k] = ext[(i + k) % 5];
            send_request(m, 1);
        end
        m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_request(m, 0);
        m = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_request(m, 0);
        // negative x with y zero gives +pi; angle sign flips across pi exercise the wrap
        m = '{16'shC000, 0, 16'shC000, 0, 0, 0, 16'shC000};
        send_request(m, 0);
        m = '{16'shC000, -16'sd1, 16'shC000, 16'sd1, 16'sd1, -16'sd1, 16'shC000};
        send_request(m, 0);
        m = '{16'shC000, 16'sd1, 16'shC000, -16'sd1, -16'sd1, 16'sd1, 16'shC000};
        send_request(m, 0);
        // sy of zero with threshold 1 takes the gimbal-lock branch
        m = '{0, 0, 16'sh4000, 16'shC000, 16'shC000, 0, 0};
        send_request(m, 0);
        drain();

        // phases across threshold settings; the last phase restores a low one
        foreach (settings[s])
        begin
            write_threshold(settings[s]);
            // hold the receiver off so the block fills up and stalls its input
            if (s == 1)
            begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (400) @(posedge clk);
                        hold_sink = 0;
                    end
                join_none
            end
            calm_sink = (s == 2);
            for (int n = 0; n < 185; n++)
            begin
                random_request(s != 2);
                // pause the sender until every result is back
                if (n == 90)
                begin
                    stop_input();
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            calm_sink = 0;
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> rotation_to_euler_with_increments.f
+incdir+hdl
hdl/rte_pkg.sv
hdl/rte_if.sv
hdl/rte_cordic.sv
hdl/rotation_to_euler_with_increments.sv
hdl/rte_checker.sv
tb/rte_tb_if.sv
tb/tb_top.sv
